@@ hdl/ttt_pkg.sv @@
package ttt_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned CntW = 32;
  localparam int unsigned VolInW = 16;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_SUM    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN,
    ST_TRIM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [CntW-1:0] cnt;
    logic [CntW-1:0] vol;
  } entry_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic live;
  } head_ctrl_t;

  typedef struct packed {
    logic inserted;
  } head_stat_t;

endpackage

@@ hdl/ttt_cell.sv @@
module ttt_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  ttt_pkg::entry_t d_i,
  output ttt_pkg::entry_t q_o
);

  ttt_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

@@ hdl/ttt_head.sv @@
module ttt_head (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttt_pkg::head_ctrl_t           ctrl_i,
  input  ttt_pkg::op_e                  op_i,
  input  logic [ttt_pkg::KeyW-1:0]      ts_i,
  input  logic [ttt_pkg::VolInW-1:0]    vol_i,
  input  logic [ttt_pkg::KeyW-1:0]      end_i,
  input  ttt_pkg::entry_t               head_i,
  output ttt_pkg::entry_t               push_o,
  output ttt_pkg::head_stat_t           stat_o,
  output logic [ttt_pkg::CntW-1:0]      packets_o,
  output logic [ttt_pkg::CntW-1:0]      bytes_o,
  output logic [ttt_pkg::CntW-1:0]      sum_o
);

  ttt_pkg::entry_t           hold_q, hold_d;
  logic                      inserted_q, inserted_d;
  logic                      hit_q, hit_d;
  logic [ttt_pkg::CntW-1:0]  packets_q, packets_d;
  logic [ttt_pkg::CntW-1:0]  bytes_q, bytes_d;
  logic [ttt_pkg::CntW-1:0]  sum_q, sum_d;
  logic [ttt_pkg::CntW-1:0]  vol_ext;

  assign vol_ext = {{(ttt_pkg::CntW-ttt_pkg::VolInW){1'b0}}, vol_i};

  always_comb begin
    push_o     = head_i;
    hold_d     = hold_q;
    inserted_d = inserted_q;
    hit_d      = hit_q;
    packets_d  = packets_q;
    bytes_d    = bytes_q;
    sum_d      = sum_q;
    if (ctrl_i.start) begin
      inserted_d = 1'b0;
      hit_d      = 1'b0;
      packets_d  = '0;
      bytes_d    = '0;
      sum_d      = '0;
    end else if (ctrl_i.scan) begin
      case (op_i)
        ttt_pkg::OP_APPEND: begin
          if (inserted_q) begin
            push_o = hold_q;
            hold_d = head_i;
          end else if (!hit_q && ctrl_i.live && head_i.key == ts_i) begin
            push_o.cnt = head_i.cnt + 1'b1;
            push_o.vol = head_i.vol + vol_ext;
            hit_d      = 1'b1;
          end else if (!hit_q && (!ctrl_i.live || head_i.key > ts_i)) begin
            push_o.key = ts_i;
            push_o.cnt = {{(ttt_pkg::CntW-1){1'b0}}, 1'b1};
            push_o.vol = vol_ext;
            hold_d     = head_i;
            inserted_d = 1'b1;
          end
        end
        ttt_pkg::OP_LOOKUP: begin
          if (ctrl_i.live && head_i.key == ts_i) begin
            packets_d = head_i.cnt;
            bytes_d   = head_i.vol;
          end
        end
        ttt_pkg::OP_SUM: begin
          if (ctrl_i.live && head_i.key > ts_i && head_i.key <= end_i) begin
            sum_d = sum_q + head_i.vol;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inserted_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      inserted_q <= inserted_d;
      hit_q      <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q    <= hold_d;
    packets_q <= packets_d;
    bytes_q   <= bytes_d;
    sum_q     <= sum_d;
  end

  assign stat_o.inserted = inserted_q;
  assign packets_o       = packets_q;
  assign bytes_o         = bytes_q;
  assign sum_o           = sum_q;

endmodule

@@ hdl/timestamped_traffic_table_core.sv @@
// A lookup or sum result is offered after a full turn of the LIMIT+1 entry ring, a finishing
// state, then the output state, where it waits for m_axis_tready. New transfers are taken only
// while idle. When an append overflows the table, the LIMIT+1-min(KEEP,LIMIT) oldest entries
// are rotated out before the next transfer is taken. Reset empties the table at once.
module timestamped_traffic_table_core #(
  parameter int unsigned LIMIT = 600,
  parameter int unsigned KEEP  = 300
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // timestamp [31:0], traffic_volume [47:32], range_end [79:48]
  input  logic [79:0] s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // entry_packets [31:0], entry_bytes [63:32], range_bytes [95:64]
  output logic [95:0] m_axis_tdata
);

  localparam int unsigned Depth   = LIMIT + 1;
  localparam int unsigned KeepEff = (KEEP < LIMIT) ? KEEP : LIMIT;
  localparam int unsigned Drop    = LIMIT + 1 - KeepEff;
  localparam int unsigned CW      = $clog2(Depth + 1);

  ttt_pkg::state_e             state_q, state_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [CW-1:0]               used_q, used_d;
  ttt_pkg::op_e                op_q;
  logic [ttt_pkg::KeyW-1:0]    ts_q;
  logic [ttt_pkg::VolInW-1:0]  vol_q;
  logic [ttt_pkg::KeyW-1:0]    end_q;
  logic                        accept;
  logic                        shift;
  logic [CW-1:0]               used_new;

  ttt_pkg::head_ctrl_t         ctrl;
  ttt_pkg::head_stat_t         stat;
  ttt_pkg::entry_t             push;
  ttt_pkg::entry_t             chain [Depth];
  logic [ttt_pkg::CntW-1:0]    packets, bytes, sum;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign used_new = used_q + CW'(stat.inserted);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    used_d        = used_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    shift         = 1'b0;
    ctrl.start    = 1'b0;
    ctrl.scan     = 1'b0;
    ctrl.live     = cnt_q < used_q;
    case (state_q)
      ttt_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          ctrl.start = 1'b1;
          cnt_d      = '0;
          if (s_axis_tuser == ttt_pkg::OP_APPEND || s_axis_tuser == ttt_pkg::OP_LOOKUP ||
              s_axis_tuser == ttt_pkg::OP_SUM) begin
            state_d = ttt_pkg::ST_SCAN;
          end
        end
      end
      ttt_pkg::ST_SCAN: begin
        shift     = 1'b1;
        ctrl.scan = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CW'(Depth - 1)) begin
          state_d = ttt_pkg::ST_FIN;
        end
      end
      ttt_pkg::ST_FIN: begin
        cnt_d = '0;
        if (op_q == ttt_pkg::OP_APPEND) begin
          if (used_new > CW'(LIMIT)) begin
            state_d = ttt_pkg::ST_TRIM;
          end else begin
            used_d  = used_new;
            state_d = ttt_pkg::ST_IDLE;
          end
        end else begin
          state_d = ttt_pkg::ST_OUT;
        end
      end
      ttt_pkg::ST_TRIM: begin
        shift = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(Drop - 1)) begin
          used_d  = CW'(KeepEff);
          state_d = ttt_pkg::ST_IDLE;
        end
      end
      ttt_pkg::ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_d = ttt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ttt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttt_pkg::ST_IDLE;
      cnt_q   <= '0;
      used_q  <= '0;
      op_q    <= ttt_pkg::OP_APPEND;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      if (accept) begin
        op_q <= ttt_pkg::op_e'(s_axis_tuser);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ts_q  <= s_axis_tdata[31:0];
      vol_q <= s_axis_tdata[47:32];
      end_q <= s_axis_tdata[79:48];
    end
  end

  ttt_head u_head (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .op_i      (op_q),
    .ts_i      (ts_q),
    .vol_i     (vol_q),
    .end_i     (end_q),
    .head_i    (chain[0]),
    .push_o    (push),
    .stat_o    (stat),
    .packets_o (packets),
    .bytes_o   (bytes),
    .sum_o     (sum)
  );

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i == Depth - 1) begin : g_tail
      ttt_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .d_i     (push),
        .q_o     (chain[i])
      );
    end else begin : g_body
      ttt_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .d_i     (chain[i+1]),
        .q_o     (chain[i])
      );
    end
  end

  assign m_axis_tdata = {sum, bytes, packets};

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(LIMIT))
    else $error("entry count exceeds the table limit");

  a_trim_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ttt_pkg::ST_TRIM |-> op_q == ttt_pkg::OP_APPEND)
    else $error("trim entered for an operation other than append");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while a result is pending");

  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ttt_pkg::ST_FIN |-> $past(cnt_q) == CW'(Depth - 1))
    else $error("ring turn ended early");

endmodule

@@ bench/timestamped_traffic_table_core_tb.sv @@
`timescale 1ns / 100ps

module timestamped_traffic_table_core_tb;

  localparam int unsigned LIMIT = 600;
  localparam int unsigned KEEP = 300;
  localparam int unsigned DEPTH = LIMIT + 1;
  localparam int unsigned TURN = 2 * LIMIT + 10;
  localparam longint CYCLE_LIMIT = 12000000;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam longint QUIET_FROM = 150000;
  localparam longint QUIET_TO = 260000;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] stamp;
    logic [15:0] volume;
    logic [31:0] stop;
    bit          drain;
  } traffic_req_t;

  typedef struct {
    logic [31:0] packets;
    logic [31:0] bytes;
    logic [31:0] span_bytes;
  } traffic_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;

  traffic_req_t pending_reqs[$];
  traffic_res_t expected_results[$];
  logic [31:0]  known_stamps[$];
  logic [31:0]  table_stamp[DEPTH];
  logic [31:0]  table_packets[DEPTH];
  logic [31:0]  table_bytes[DEPTH];
  int unsigned  table_used;
  int unsigned  error_count;
  longint       cycle_count = 0;

  timestamped_traffic_table_core #(
    .LIMIT(LIMIT),
    .KEEP (KEEP)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int unsigned first_at_or_above(input logic [31:0] stamp);
    int unsigned idx;
    idx = 0;
    while (idx < table_used && table_stamp[idx] < stamp) idx++;
    return idx;
  endfunction

  function automatic void record_traffic(input logic [31:0] stamp, input logic [15:0] volume);
    int unsigned pos;
    int unsigned keep_n;
    int unsigned drop_n;
    pos = first_at_or_above(stamp);
    if (pos < table_used && table_stamp[pos] == stamp) begin
      table_packets[pos] += 32'd1;
      table_bytes[pos] += {16'd0, volume};
    end else begin
      for (int i = table_used; i > pos; i--) begin
        table_stamp[i] = table_stamp[i-1];
        table_packets[i] = table_packets[i-1];
        table_bytes[i] = table_bytes[i-1];
      end
      table_stamp[pos] = stamp;
      table_packets[pos] = 32'd1;
      table_bytes[pos] = {16'd0, volume};
      table_used++;
    end
    if (table_used > LIMIT) begin
      keep_n = (KEEP < LIMIT) ? KEEP : LIMIT;
      drop_n = table_used - keep_n;
      for (int i = 0; i < keep_n; i++) begin
        table_stamp[i] = table_stamp[i+drop_n];
        table_packets[i] = table_packets[i+drop_n];
        table_bytes[i] = table_bytes[i+drop_n];
      end
      table_used = keep_n;
    end
  endfunction

  function automatic void predict_traffic(input traffic_req_t req);
    traffic_res_t res;
    int unsigned  idx;
    res = '{32'd0, 32'd0, 32'd0};
    case (req.op)
      ttt_pkg::OP_APPEND: begin
        record_traffic(req.stamp, req.volume);
      end
      ttt_pkg::OP_LOOKUP: begin
        idx = first_at_or_above(req.stamp);
        if (idx < table_used && table_stamp[idx] == req.stamp) begin
          res.packets = table_packets[idx];
          res.bytes = table_bytes[idx];
        end
        expected_results.push_back(res);
      end
      ttt_pkg::OP_SUM: begin
        idx = 0;
        while (idx < table_used && table_stamp[idx] <= req.stamp) idx++;
        while (idx < table_used && table_stamp[idx] <= req.stop) begin
          res.span_bytes += table_bytes[idx];
          idx++;
        end
        expected_results.push_back(res);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_stamp();
    if (known_stamps.size() != 0 && $urandom_range(0, 99) < 60)
      return known_stamps[$urandom_range(0, known_stamps.size() - 1)];
    return $urandom();
  endfunction

  function automatic void queue_req(input logic [1:0] op, input logic [31:0] stamp,
                                    input logic [15:0] volume, input logic [31:0] stop,
                                    input bit drain);
    traffic_req_t req;
    req = '{op, stamp, volume, stop, drain};
    if (op == ttt_pkg::OP_APPEND) known_stamps.push_back(stamp);
    pending_reqs.push_back(req);
  endfunction

  function automatic void queue_random(input int unsigned append_pct, input bit fresh);
    int unsigned roll;
    logic [31:0] a;
    logic [31:0] b;
    roll = $urandom_range(0, 99);
    if (roll < append_pct) begin
      a = fresh ? $urandom() : pick_stamp();
      queue_req(ttt_pkg::OP_APPEND, a, 16'($urandom()), $urandom(), 1'b0);
    end else if (roll < append_pct + (100 - append_pct) / 2) begin
      queue_req(ttt_pkg::OP_LOOKUP, pick_stamp(), 16'($urandom()), $urandom(), 1'b0);
    end else if (roll < 97) begin
      a = pick_stamp();
      b = pick_stamp();
      if ($urandom_range(0, 3) != 0 && a > b)
        queue_req(ttt_pkg::OP_SUM, b, 16'($urandom()), a, 1'b0);
      else queue_req(ttt_pkg::OP_SUM, a, 16'($urandom()), b, 1'b0);
    end else begin
      queue_req(OP_RESERVED, $urandom(), 16'($urandom()), $urandom(), 1'b0);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_reqs.size() == 0 ||
          (pending_reqs[0].drain && expected_results.size() != 0) ||
          ((cycle_count < QUIET_FROM || cycle_count > QUIET_TO) &&
           $urandom_range(0, 99) < 31)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pending_reqs[0].stop, pending_reqs[0].volume, pending_reqs[0].stamp};
        s_axis_tuser <= pending_reqs[0].op;
        void'(pending_reqs.pop_front());
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (cycle_count >= QUIET_FROM && cycle_count <= QUIET_TO) ||
                       ($urandom_range(0, 99) >= 31);
    end
  end

  always @(posedge clk_i) begin
    traffic_req_t req;
    traffic_res_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        req = '{s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[47:32], s_axis_tdata[79:48],
                1'b0};
        predict_traffic(req);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", m_axis_tdata[31:0], 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[31:0] !== want.packets)
            report_mismatch("entry_packets", m_axis_tdata[31:0], want.packets);
          if (m_axis_tdata[63:32] !== want.bytes)
            report_mismatch("entry_bytes", m_axis_tdata[63:32], want.bytes);
          if (m_axis_tdata[95:64] !== want.span_bytes)
            report_mismatch("range_bytes", m_axis_tdata[95:64], want.span_bytes);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timestamped_traffic_table_core verification failed");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    table_used = 0;
    rst_ni = 1'b0;

    queue_req(ttt_pkg::OP_LOOKUP, 32'd0, 16'd0, 32'd0, 1'b0);
    queue_req(ttt_pkg::OP_SUM, 32'd0, 16'd0, 32'hFFFF_FFFF, 1'b0);
    queue_req(ttt_pkg::OP_APPEND, 32'd0, 16'd0, 32'd0, 1'b0);
    queue_req(ttt_pkg::OP_APPEND, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_req(ttt_pkg::OP_APPEND, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 1'b0);
    queue_req(ttt_pkg::OP_APPEND, 32'h8000_0000, 16'h5A5A, 32'h1234_5678, 1'b0);
    queue_req(ttt_pkg::OP_APPEND, 32'h8000_0000, 16'hA5A5, 32'hEDCB_A987, 1'b0);
    queue_req(ttt_pkg::OP_LOOKUP, 32'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_req(ttt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 16'd0, 32'd0, 1'b0);
    queue_req(ttt_pkg::OP_LOOKUP, 32'h8000_0000, 16'd0, 32'd0, 1'b0);
    queue_req(ttt_pkg::OP_LOOKUP, 32'h0000_0001, 16'd0, 32'd0, 1'b0);
    queue_req(ttt_pkg::OP_SUM, 32'd0, 16'd0, 32'hFFFF_FFFF, 1'b0);
    queue_req(ttt_pkg::OP_SUM, 32'hFFFF_FFFF, 16'd0, 32'd0, 1'b0);
    queue_req(ttt_pkg::OP_SUM, 32'h8000_0000, 16'd0, 32'h8000_0000, 1'b0);
    queue_req(ttt_pkg::OP_SUM, 32'h7FFF_FFFF, 16'd0, 32'h8000_0000, 1'b0);
    queue_req(ttt_pkg::OP_SUM, 32'hFFFF_FFFE, 16'd0, 32'hFFFF_FFFF, 1'b0);
    queue_req(OP_RESERVED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_req(OP_RESERVED, 32'd0, 16'd0, 32'd0, 1'b0);
    queue_req(ttt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 16'd0, 32'd0, 1'b1);

    for (int i = 0; i < 160; i++) queue_random(50, 1'b0);
    queue_req(ttt_pkg::OP_SUM, 32'd0, 16'd0, 32'hFFFF_FFFF, 1'b1);
    // Mostly fresh stamps so that the table grows.
    for (int i = 0; i < 180; i++) queue_random(85, 1'b1);
    queue_req(ttt_pkg::OP_SUM, 32'd0, 16'd0, 32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 140; i++) queue_random(45, 1'b0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_reqs.size() == 0 && expected_results.size() == 0);
    repeat (TURN) @(posedge clk_i);
    wait (expected_results.size() == 0);
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("timestamped_traffic_table_core verification clean");
    end else begin
      $display("timestamped_traffic_table_core verification failed");
    end
    $finish;
  end

endmodule
